// ===== src/lfbc_pkg.sv =====
package lfbc_pkg;

  localparam int XLEN = 64;

  localparam int DEF_REGION_SHIFT   = 32;
  localparam int DEF_MIN_SIZE_SHIFT = 4;
  localparam int DEF_NUM_REGIONS    = 64;

  localparam int FUNC_W  = 3;
  localparam int EIDX_W  = 6;
  localparam int FAULT_W = 2;
  localparam int CFG_IDX_W = 1;

  // in_tdata layout, lowest bit up
  localparam int IN_DATA_W = 328;
  localparam int IN_PTR_LO = 0;
  localparam int IN_WIT_LO = 64;
  localparam int IN_SZ_LO  = 128;
  localparam int IN_EI_LO  = 192;
  localparam int IN_EM_LO  = 198;
  localparam int IN_ES_LO  = 262;

  localparam int OUT_DATA_W = 72;

  localparam logic [FUNC_W-1:0] FN_WRITE   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEREF   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INNER   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_OUTFLOW = 3'd3;
  localparam logic [FUNC_W-1:0] FN_LOWER   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_UPPER   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SIZEIDX = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD    = 3'd7;

  localparam logic [FAULT_W-1:0] FAULT_NONE    = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_DEREF   = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OUTFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_OVERFLOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_UPPER      = 1'd1;

  typedef struct packed {
    logic [XLEN-1:0] mask;
    logic [XLEN-1:0] size;
  } entry_t;

  // word handed from address arithmetic to the compare/select stage
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               fat;
    logic [XLEN-1:0]    diff;
    logic [XLEN-1:0]    lim;
    logic               ovf;
    logic [XLEN-1:0]    pre;
    logic [7:0]         grp_nz;
    logic [7:0][2:0]    grp_pos;
    logic               pow2;
    logic               zero;
  } s2_t;

endpackage

// ===== src/lfbc_table.sv =====
module lfbc_table import lfbc_pkg::*; #(
  parameter int NUM_REGIONS = DEF_NUM_REGIONS,
  localparam int IW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr_a,
  input  logic          rok_a,
  input  logic [IW-1:0] raddr_b,
  input  logic          rok_b,
  output entry_t        rdata_a,
  output entry_t        rdata_b
);

  entry_t mem [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] vld_r;
  entry_t rd_a_r, rd_b_r;
  logic   rv_a_r, rv_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rv_a_r <= 1'b0;
      rv_b_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rv_a_r <= rok_a & vld_r[raddr_a];
        rv_b_r <= rok_b & vld_r[raddr_b];
      end
    end
  end

  // unwritten or out-of-range regions read as mask 0, size all ones
  assign rdata_a = rv_a_r ? rd_a_r : entry_t'{mask: '0, size: '1};
  assign rdata_b = rv_b_r ? rd_b_r : entry_t'{mask: '0, size: '1};

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> vld_r[$past(waddr)])
    else $error("table write did not mark entry valid");

endmodule

// ===== src/lfbc_eval.sv =====
module lfbc_eval import lfbc_pkg::*; #(
  parameter int MIN_SIZE_SHIFT = DEF_MIN_SIZE_SHIFT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  s2_t                   s1_word,
  output logic                  s2_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FAULT_W-1:0]    out_fault,
  output logic [XLEN-1:0]       out_value,
  output logic                  out_fat
);

  s2_t  s2_r;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic out_free, s2_ld, out_ld;

  logic [FAULT_W-1:0] fault_nxt;
  logic [XLEN-1:0]    value_nxt;
  logic               fat_nxt;
  logic [2:0]         hg, hp;
  logic [6:0]         bits, idx;
  logic               over;

  assign out_free = !out_v_r || out_ready;
  assign s2_ready = !s2_v_r || out_free;
  assign s2_ld    = s1_valid && s2_ready;
  assign out_ld   = s2_v_r && out_free;

  assign s2_v_nxt  = s2_ld ? 1'b1 : (out_ld ? 1'b0 : s2_v_r);
  assign out_v_nxt = out_ld ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // highest set bit of the size operand from the per-byte encodings
  always_comb begin
    hg = 3'd0;
    hp = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (s2_r.grp_nz[g]) begin
        hg = 3'(g);
        hp = s2_r.grp_pos[g];
      end
    end
    bits = 7'({hg, hp}) + 7'd1;
    if (s2_r.zero || bits <= 7'(MIN_SIZE_SHIFT)) begin
      idx = 7'd1;
    end else begin
      idx = bits - 7'(MIN_SIZE_SHIFT) + 7'(!s2_r.pow2);
    end
  end

  assign over = s2_r.diff > s2_r.lim;

  always_comb begin
    fault_nxt = FAULT_NONE;
    value_nxt = '0;
    fat_nxt   = s2_r.fat;
    unique case (s2_r.func)
      FN_DEREF, FN_INNER: begin
        if (s2_r.ovf || over) fault_nxt = FAULT_DEREF;
      end
      FN_OUTFLOW: begin
        if (over) fault_nxt = FAULT_OUTFLOW;
      end
      FN_LOWER, FN_UPPER: value_nxt = s2_r.pre;
      FN_SIZEIDX:         value_nxt = XLEN'(idx);
      default:            fat_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      s2_r <= s1_word;
    end
    if (out_ld) begin
      out_fault <= fault_nxt;
      out_value <= value_nxt;
      out_fat   <= fat_nxt;
    end
  end

  assign out_valid = out_v_r;

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !out_free |=> s2_v_r)
    else $error("stage 2 word lost while output stalled");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ready |=> out_v_r && $stable(out_value))
    else $error("result word changed while stalled");

endmodule

// ===== src/lowfat_bounds_check.sv =====
// Low-fat pointer bounds checker. One item is accepted per cycle while out_tready does
// not stall the pipeline; its result word passes through a table read (synchronous RAM,
// read at the pointer's and the witness's region in the same cycle), a stage of address
// arithmetic, and a compare/select stage that feeds the output register. Throughput is
// one word per cycle without back-pressure, with one table write port and two read ports.
// The table entries carry valid bits cleared at reset, so there is no clearing pass; a
// table write is visible to the very next item. Configuration goes in on the cfg_ channel
// (always ready); the user writes it only while the block is idle; the block never checks.
module lowfat_bounds_check import lfbc_pkg::*; #(
  parameter int REGION_SHIFT   = DEF_REGION_SHIFT,
  parameter int MIN_SIZE_SHIFT = DEF_MIN_SIZE_SHIFT,
  parameter int NUM_REGIONS    = DEF_NUM_REGIONS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pointer, witness_ptr, size_operand, entry_index, entry_mask, entry_size, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func
  input  logic [FUNC_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // fault_code, value, is_fat, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [XLEN-1:0]       cfg_data
);

  localparam int IW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  logic [XLEN-1:0] in_ptr, in_wit, in_sz, in_em, in_es;
  logic [EIDX_W-1:0] in_ei;
  logic in_acc;

  assign in_ptr = in_tdata[IN_PTR_LO +: XLEN];
  assign in_wit = in_tdata[IN_WIT_LO +: XLEN];
  assign in_sz  = in_tdata[IN_SZ_LO  +: XLEN];
  assign in_ei  = in_tdata[IN_EI_LO  +: EIDX_W];
  assign in_em  = in_tdata[IN_EM_LO  +: XLEN];
  assign in_es  = in_tdata[IN_ES_LO  +: XLEN];

  // config registers
  logic            report_overflow_r;
  logic [XLEN-1:0] wide_upper_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_overflow_r <= 1'b0;
      wide_upper_r      <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REPORT_OVERFLOW: report_overflow_r <= cfg_data[0];
        CFG_WIDE_UPPER:      wide_upper_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: table read issued at accept
  logic [XLEN-1:0] ptr_reg, wit_reg;
  logic            ptr_ok, wit_ok, wr_ok, tbl_we;
  entry_t          pe, we_ent;
  s2_t             s1_word;
  logic            s2_ready;

  logic                s1_v_r, s1_v_nxt;
  logic [FUNC_W-1:0]   s1_func_r;
  logic [XLEN-1:0]     s1_ptr_r, s1_wit_r, s1_sz_r;

  assign ptr_reg = in_ptr >> REGION_SHIFT;
  assign wit_reg = in_wit >> REGION_SHIFT;
  assign ptr_ok  = ptr_reg < XLEN'(NUM_REGIONS);
  assign wit_ok  = wit_reg < XLEN'(NUM_REGIONS);
  assign wr_ok   = {26'd0, in_ei} < 32'(NUM_REGIONS);

  assign in_tready = !s1_v_r || s2_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign tbl_we    = in_acc && (in_tuser == FN_WRITE) && wr_ok;

  assign s1_v_nxt = in_acc ? 1'b1 : ((s1_v_r && s2_ready) ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r <= in_tuser;
      s1_ptr_r  <= in_ptr;
      s1_wit_r  <= in_wit;
      s1_sz_r   <= in_sz;
    end
  end

  lfbc_table #(
    .NUM_REGIONS(NUM_REGIONS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (tbl_we),
    .waddr   (IW'(in_ei)),
    .wdata   (entry_t'{mask: in_em, size: in_es}),
    .re      (in_acc),
    .raddr_a (IW'(ptr_reg)),
    .rok_a   (ptr_ok),
    .raddr_b (IW'(wit_reg)),
    .rok_b   (wit_ok),
    .rdata_a (pe),
    .rdata_b (we_ent)
  );

  // address arithmetic
  logic [XLEN-1:0] pbase, base, subtr;
  logic [XLEN:0]   lim_w;
  logic            is_out;

  assign pbase  = s1_ptr_r & pe.mask;
  assign base   = (s1_func_r == FN_DEREF) ? s1_wit_r : (s1_wit_r & we_ent.mask);
  assign is_out = s1_func_r == FN_OUTFLOW;
  assign subtr  = is_out ? XLEN'(1) : s1_sz_r;
  assign lim_w  = {1'b0, we_ent.size} - {1'b0, subtr};

  always_comb begin
    s1_word.func  = s1_func_r;
    s1_word.fat   = pbase != '0;
    s1_word.diff  = s1_ptr_r - base;
    s1_word.lim   = lim_w[XLEN-1:0];
    // borrow of the limit subtract is alloc < width
    s1_word.ovf   = report_overflow_r && !is_out && lim_w[XLEN];
    if (s1_func_r == FN_UPPER) begin
      s1_word.pre = (pbase != '0) ? (pbase + pe.size) : wide_upper_r;
    end else begin
      s1_word.pre = pbase;
    end
    for (int g = 0; g < 8; g++) begin
      s1_word.grp_nz[g]  = |s1_sz_r[8*g +: 8];
      s1_word.grp_pos[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (s1_sz_r[8*g + b]) s1_word.grp_pos[g] = 3'(b);
      end
    end
    s1_word.pow2 = (s1_sz_r & (s1_sz_r - XLEN'(1))) == '0;
    s1_word.zero = s1_sz_r == '0;
  end

  logic [FAULT_W-1:0] res_fault;
  logic [XLEN-1:0]    res_value;
  logic               res_fat;

  lfbc_eval #(
    .MIN_SIZE_SHIFT(MIN_SIZE_SHIFT)
  ) u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_v_r),
    .s1_word   (s1_word),
    .s2_ready  (s2_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_fault (res_fault),
    .out_value (res_value),
    .out_fat   (res_fat)
  );

  assign out_tdata = {5'd0, res_fat, res_value, res_fault};

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_ready |=> s1_v_r && $stable(s1_func_r) && $stable(s1_ptr_r))
    else $error("stage 1 word dropped or overrun while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_tready)
    else $error("input not ready with empty table-read stage");

endmodule
